### rtl/core/dbp_pkg.sv
// Shared types, widths and codes for the depth back-projection unit.
`default_nettype none

package dbp_pkg;

   // Payload widths of the channels
   localparam int DEPTH_W    = 32;
   localparam int MASK_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int COORD_OUT_W = 32;
   localparam int POINT_Z_W  = 31;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Register widths
   localparam int WIDTH_REG_W = 11;
   localparam int STEP_REG_W  = 5;
   localparam int SCALE_W     = 24;
   localparam int CENTER_W    = 16;
   localparam int INV_W       = 32;

   // Datapath widths: pixel offset in Q14.4, its magnitude, multiplier and partial sums
   localparam int COORD_W  = 18;
   localparam int MAG_W    = 17;
   localparam int MUL_W    = 32;
   localparam int PROD_W   = 64;
   localparam int SCALED_W = 40;
   localparam int HI_W     = 56;
   localparam int LO_W     = 24;
   localparam int Q_W      = 45;

   // Pass threshold of the mask level
   localparam logic [MASK_W-1:0] MASK_THRESHOLD = 8'd128;

   // Saturation limits
   localparam logic [SCALED_W-1:0] DEPTH_LIMIT = 40'h00_7FFF_FFFF;
   localparam logic [Q_W-1:0]      Q_POS_LIMIT = 45'h0000_7FFF_FFFF;
   localparam logic [Q_W-1:0]      Q_NEG_LIMIT = 45'h0000_8000_0000;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_SAMPLE_STEP  = 3'd1,
      REG_DEPTH_SHIFT  = 3'd2,
      REG_DEPTH_GAIN   = 3'd3,
      REG_CENTER_X     = 3'd4,
      REG_CENTER_Y     = 3'd5,
      REG_INV_FX       = 3'd6,
      REG_INV_FY       = 3'd7
   } csr_reg_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DEPTH,
      ST_AX,
      ST_HX,
      ST_LX,
      ST_SX,
      ST_FX,
      ST_AY,
      ST_HY,
      ST_LY,
      ST_SY,
      ST_FY,
      ST_OUT
   } state_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SCALE,
      OP_DEPTH,
      OP_AMUL,
      OP_HMUL,
      OP_LMUL,
      OP_QSUM,
      OP_SAT,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   axis_y;
   } dp_cmd_type;

   typedef struct packed {
      logic keep;
      logic depth_zero;
   } dp_status_type;

   typedef struct packed {
      logic [WIDTH_REG_W-1:0] image_width;
      logic [STEP_REG_W-1:0]  sample_step;
      logic signed [DEPTH_W-1:0] depth_shift;
      logic [SCALE_W-1:0]     depth_gain;
      logic [CENTER_W-1:0]    center_x;
      logic [CENTER_W-1:0]    center_y;
      logic [INV_W-1:0]       inv_fx;
      logic [INV_W-1:0]       inv_fy;
   } cfg_type;

   typedef struct packed {
      logic signed [DEPTH_W-1:0] model_depth;
      logic [MASK_W-1:0]  mask_level;
      logic [COLOR_W-1:0] red_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] blue_in;
      logic               frame_start;
   } pixel_type;

   typedef struct packed {
      logic signed [COORD_OUT_W-1:0] point_x;
      logic signed [COORD_OUT_W-1:0] point_y;
      logic [POINT_Z_W-1:0] point_z;
      logic                 point_valid;
      logic [COLOR_W-1:0]   red_out;
      logic [COLOR_W-1:0]   green_out;
      logic [COLOR_W-1:0]   blue_out;
      logic                 row_last;
   } point_type;

endpackage

`default_nettype wire

### rtl/core/dbp_chan_if.sv
// Channel interfaces of the depth back-projection unit: pixels in, points out, registers.
`default_nettype none

interface dbp_req_if;
   import dbp_pkg::*;

   logic valid;
   logic ready;
   logic signed [DEPTH_W-1:0] model_depth;
   logic [MASK_W-1:0]  mask_level;
   logic [COLOR_W-1:0] red_in;
   logic [COLOR_W-1:0] green_in;
   logic [COLOR_W-1:0] blue_in;
   logic               frame_start;

   modport source (output valid, model_depth, mask_level, red_in, green_in, blue_in,
                   frame_start, input ready);
   modport sink   (input valid, model_depth, mask_level, red_in, green_in, blue_in,
                   frame_start, output ready);
endinterface

interface dbp_rsp_if;
   import dbp_pkg::*;

   logic valid;
   logic ready;
   logic signed [COORD_OUT_W-1:0] point_x;
   logic signed [COORD_OUT_W-1:0] point_y;
   logic [POINT_Z_W-1:0] point_z;
   logic                 point_valid;
   logic [COLOR_W-1:0]   red_out;
   logic [COLOR_W-1:0]   green_out;
   logic [COLOR_W-1:0]   blue_out;
   logic                 row_last;

   modport source (output valid, point_x, point_y, point_z, point_valid, red_out,
                   green_out, blue_out, row_last, input ready);
   modport sink   (input valid, point_x, point_y, point_z, point_valid, red_out,
                   green_out, blue_out, row_last, output ready);
endinterface

interface dbp_csr_if;
   import dbp_pkg::*;

   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/depth_backprojection_point_cloud_unit.sv
// A kept pixel is captured in IDLE, its depth scaled in SCALE and DEPTH, x projected in AX to
// FX and y in AY to FY, and the point loaded in OUT; a zero depth goes from AX to OUT, and a
// dropped pixel gives no result. One pixel at a time: the next beat is taken the cycle after
// the result is loaded, OUT waits while the result register is full, and the pace is set by
// the seven passes through the shared 32x32 multiplier. Synchronous active-high reset clears
// the counters, the sequencer, the result valid and returns the registers to their defaults.
`default_nettype none

module depth_backprojection_point_cloud_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_STEP   = 16
) (
   input logic        clock,
   input logic        reset,
   dbp_req_if.sink    req_bus,
   dbp_rsp_if.source  rsp_bus,
   dbp_csr_if.sink    csr_bus
);
   import dbp_pkg::*;

   cfg_type       cfg_ff;
   pixel_type     pixel;
   point_type     point;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   // Register file; writes are always taken
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 11'd1024;
         cfg_ff.sample_step  <= 5'd1;
         cfg_ff.depth_shift  <= '0;
         cfg_ff.depth_gain   <= '0;
         cfg_ff.center_x     <= '0;
         cfg_ff.center_y     <= '0;
         cfg_ff.inv_fx       <= '0;
         cfg_ff.inv_fy       <= '0;
      end else if (csr_bus.valid) begin
         case (csr_reg_type'(csr_bus.index))
            REG_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_bus.data[WIDTH_REG_W-1:0];
            REG_SAMPLE_STEP:  cfg_ff.sample_step  <= csr_bus.data[STEP_REG_W-1:0];
            REG_DEPTH_SHIFT:  cfg_ff.depth_shift  <= $signed(csr_bus.data);
            REG_DEPTH_GAIN:   cfg_ff.depth_gain   <= csr_bus.data[SCALE_W-1:0];
            REG_CENTER_X:     cfg_ff.center_x     <= csr_bus.data[CENTER_W-1:0];
            REG_CENTER_Y:     cfg_ff.center_y     <= csr_bus.data[CENTER_W-1:0];
            REG_INV_FX:       cfg_ff.inv_fx       <= csr_bus.data[INV_W-1:0];
            REG_INV_FY:       cfg_ff.inv_fy       <= csr_bus.data[INV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pixel beat into the datapath
   assign pixel.model_depth = req_bus.model_depth;
   assign pixel.mask_level  = req_bus.mask_level;
   assign pixel.red_in      = req_bus.red_in;
   assign pixel.green_in    = req_bus.green_in;
   assign pixel.blue_in     = req_bus.blue_in;
   assign pixel.frame_start = req_bus.frame_start;

   dbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dbp_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_STEP   (MAX_STEP)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .pixel  (pixel),
      .cmd    (cmd),
      .status (status),
      .point  (point)
   );

   // Point beat out of the result register
   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.point_x     = point.point_x;
   assign rsp_bus.point_y     = point.point_y;
   assign rsp_bus.point_z     = point.point_z;
   assign rsp_bus.point_valid = point.point_valid;
   assign rsp_bus.red_out     = point.red_out;
   assign rsp_bus.green_out   = point.green_out;
   assign rsp_bus.blue_out    = point.blue_out;
   assign rsp_bus.row_last    = point.row_last;

endmodule

`default_nettype wire

### rtl/core/dbp_ctrl.sv
// Sequencer of the depth back-projection unit: steps the datapath through one pixel.
`default_nettype none

module dbp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  dbp_pkg::dp_status_type status,
   output dbp_pkg::dp_cmd_type    cmd
);
   import dbp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      out_free;

   // The result register can take a new point when empty or being drained this cycle
   assign out_free = !out_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.keep) state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_DEPTH;
         ST_DEPTH: state_in = ST_AX;
         ST_AX: begin
            state_in = status.depth_zero ? ST_OUT : ST_HX;
         end
         ST_HX:  state_in = ST_LX;
         ST_LX:  state_in = ST_SX;
         ST_SX:  state_in = ST_FX;
         ST_FX:  state_in = ST_AY;
         ST_AY:  state_in = ST_HY;
         ST_HY:  state_in = ST_LY;
         ST_LY:  state_in = ST_SY;
         ST_SY:  state_in = ST_FY;
         ST_FY:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath and handshake outputs
   always_comb begin
      cmd.op     = OP_NONE;
      cmd.axis_y = 1'b0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_CAPTURE;
         end
         ST_SCALE: cmd.op = OP_SCALE;
         ST_DEPTH: cmd.op = OP_DEPTH;
         ST_AX: begin
            if (!status.depth_zero) cmd.op = OP_AMUL;
         end
         ST_HX: cmd.op = OP_HMUL;
         ST_LX: cmd.op = OP_LMUL;
         ST_SX: cmd.op = OP_QSUM;
         ST_FX: cmd.op = OP_SAT;
         ST_AY: begin
            cmd.op     = OP_AMUL;
            cmd.axis_y = 1'b1;
         end
         ST_HY: begin
            cmd.op     = OP_HMUL;
            cmd.axis_y = 1'b1;
         end
         ST_LY: begin
            cmd.op     = OP_LMUL;
            cmd.axis_y = 1'b1;
         end
         ST_SY: begin
            cmd.op     = OP_QSUM;
            cmd.axis_y = 1'b1;
         end
         ST_FY: begin
            cmd.op     = OP_SAT;
            cmd.axis_y = 1'b1;
         end
         ST_OUT: begin
            if (out_free) cmd.op = OP_OUT;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   // Result valid: set when a point is loaded, cleared when the beat is taken
   always_comb begin
      if (cmd.op == OP_OUT) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

### rtl/core/dbp_dp.sv
// Datapath of the depth back-projection unit: counters, depth, shared multiplier, result.
`default_nettype none

module dbp_dp #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_STEP   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dbp_pkg::cfg_type       cfg,
   input  dbp_pkg::pixel_type     pixel,
   input  dbp_pkg::dp_cmd_type    cmd,
   output dbp_pkg::dp_status_type status,
   output dbp_pkg::point_type     point
);
   import dbp_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int PW = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int SW = $clog2(MAX_STEP + 1);

   // Raster counters
   logic [CW-1:0] col_ff, col_in, cur_col;
   logic [RW-1:0] row_ff, row_in, cur_row;
   logic [PW-1:0] cph_ff, cph_in, cur_cph;
   logic [PW-1:0] rph_ff, rph_in, cur_rph;
   logic [WW-1:0] eff_w;
   logic [SW-1:0] eff_step;

   // Captured pixel
   logic [CW-1:0]      col_cap_ff;
   logic [RW-1:0]      row_cap_ff;
   logic               row_last_ff;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic [DEPTH_W-1:0] sum_ff;
   logic signed [DEPTH_W:0] shifted;
   logic               depth_pass;

   // Arithmetic
   logic [POINT_Z_W-1:0] depth_ff;
   logic [SCALED_W-1:0]  depth_sel;
   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [PROD_W-1:0]    prod, prod_ff;
   logic [LO_W-1:0]      alo_ff;
   logic [HI_W-1:0]      hi_ff;
   logic [HI_W-1:0]      low_sum;
   logic [Q_W-1:0]       q_ff;
   logic [COORD_OUT_W-1:0] sat_val, sat_mag;
   logic signed [COORD_OUT_W-1:0] x_ff, y_ff;
   logic signed [COORD_W-1:0] dx, dy, d_sel;
   logic [MAG_W-1:0]     mag;
   logic                 neg_sel;
   point_type            point_ff;

   // Width and step as used: zero acts as one, large values clamp to the maximum
   always_comb begin
      if (cfg.image_width == '0) begin
         eff_w = WW'(1);
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(cfg.image_width);
      end
      if (cfg.sample_step == '0) begin
         eff_step = SW'(1);
      end else if (32'(cfg.sample_step) > MAX_STEP) begin
         eff_step = SW'(MAX_STEP);
      end else begin
         eff_step = SW'(cfg.sample_step);
      end
   end

   // A frame start clears the counters before this pixel is placed
   assign cur_col = pixel.frame_start ? '0 : col_ff;
   assign cur_row = pixel.frame_start ? '0 : row_ff;
   assign cur_cph = pixel.frame_start ? '0 : cph_ff;
   assign cur_rph = pixel.frame_start ? '0 : rph_ff;

   assign status.keep       = (cur_cph == '0) && (cur_rph == '0);
   assign status.depth_zero = (depth_ff == '0);

   // Counter advance
   always_comb begin
      col_in = cur_col;
      row_in = cur_row;
      cph_in = cur_cph;
      rph_in = cur_rph;
      if (32'(cur_col) + 32'd1 >= 32'(eff_w)) begin
         col_in = '0;
         cph_in = '0;
         if (32'(cur_row) + 32'd1 >= MAX_HEIGHT) begin
            row_in = '0;
            rph_in = '0;
         end else begin
            row_in = cur_row + 1'b1;
            rph_in = (32'(cur_rph) + 32'd1 >= 32'(eff_step)) ? '0 : cur_rph + 1'b1;
         end
      end else begin
         col_in = cur_col + 1'b1;
         cph_in = (32'(cur_cph) + 32'd1 >= 32'(eff_step)) ? '0 : cur_cph + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else if (cmd.op == OP_CAPTURE) begin
         col_ff <= col_in;
         row_ff <= row_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
      end
   end

   // Masked and shifted depth, clamped at zero
   assign shifted    = {pixel.model_depth[DEPTH_W-1], pixel.model_depth} +
                       {cfg.depth_shift[DEPTH_W-1], cfg.depth_shift};
   assign depth_pass = (pixel.mask_level > MASK_THRESHOLD) && !shifted[DEPTH_W] &&
                       (shifted[DEPTH_W-1:0] != '0);

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE) begin
         col_cap_ff  <= cur_col;
         row_cap_ff  <= cur_row;
         row_last_ff <= (32'(cur_col) + 32'(eff_step) >= 32'(eff_w));
         red_ff      <= pixel.red_in;
         green_ff    <= pixel.green_in;
         blue_ff     <= pixel.blue_in;
         sum_ff      <= depth_pass ? shifted[DEPTH_W-1:0] : '0;
      end
   end

   // Offsets from the principal point in Q14.4 and their magnitude
   assign dx = $signed({{(COORD_W-CW-4){1'b0}}, col_cap_ff, 4'b0000}) -
               $signed({{(COORD_W-CENTER_W){1'b0}}, cfg.center_x});
   assign dy = $signed({{(COORD_W-RW-4){1'b0}}, row_cap_ff, 4'b0000}) -
               $signed({{(COORD_W-CENTER_W){1'b0}}, cfg.center_y});
   assign d_sel   = cmd.axis_y ? dy : dx;
   assign neg_sel = d_sel[COORD_W-1];
   assign mag     = neg_sel ? MAG_W'(-d_sel) : MAG_W'(d_sel);

   // Shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SCALE: begin
            mul_a = sum_ff;
            mul_b = MUL_W'(cfg.depth_gain);
         end
         OP_AMUL: begin
            mul_a = MUL_W'(mag);
            mul_b = cmd.axis_y ? cfg.inv_fy : cfg.inv_fx;
         end
         OP_HMUL: begin
            mul_a = MUL_W'(prod_ff[HI_W-LO_W+LO_W-8:LO_W]);
            mul_b = MUL_W'(depth_ff);
         end
         OP_LMUL: begin
            mul_a = MUL_W'(alo_ff);
            mul_b = MUL_W'(depth_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Scaled depth selection, saturated when the depth is registered
   always_comb begin
      if (cfg.depth_gain != '0) begin
         depth_sel = prod_ff[SCALED_W+15:16];
      end else begin
         depth_sel = SCALED_W'(sum_ff);
      end
   end

   // Low partial product merged with the low bits of the high partial product
   assign low_sum = HI_W'({hi_ff[11:0], 24'h000000}) + HI_W'(prod_ff[HI_W-2:0]);

   // Saturation and sign of one projected coordinate
   always_comb begin
      if (neg_sel) begin
         sat_mag = (q_ff > Q_NEG_LIMIT) ? Q_NEG_LIMIT[COORD_OUT_W-1:0] : q_ff[COORD_OUT_W-1:0];
         sat_val = '0 - sat_mag;
      end else begin
         sat_mag = '0;
         sat_val = (q_ff > Q_POS_LIMIT) ? Q_POS_LIMIT[COORD_OUT_W-1:0] : q_ff[COORD_OUT_W-1:0];
      end
   end

   // Arithmetic registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_SCALE: prod_ff <= prod;
         OP_DEPTH: begin
            depth_ff <= (depth_sel > DEPTH_LIMIT) ? DEPTH_LIMIT[POINT_Z_W-1:0]
                                                  : depth_sel[POINT_Z_W-1:0];
         end
         OP_AMUL: prod_ff <= prod;
         OP_HMUL: begin
            prod_ff <= prod;
            alo_ff  <= prod_ff[LO_W-1:0];
         end
         OP_LMUL: begin
            prod_ff <= prod;
            hi_ff   <= prod_ff[HI_W-1:0];
         end
         OP_QSUM: q_ff <= Q_W'(hi_ff[HI_W-1:12]) + Q_W'(low_sum[HI_W-1:36]);
         OP_SAT: begin
            if (cmd.axis_y) begin
               y_ff <= $signed(sat_val);
            end else begin
               x_ff <= $signed(sat_val);
            end
         end
         default: begin
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         point_ff.row_last <= row_last_ff;
         if (depth_ff == '0) begin
            point_ff.point_x     <= '0;
            point_ff.point_y     <= '0;
            point_ff.point_z     <= '0;
            point_ff.point_valid <= 1'b0;
            point_ff.red_out     <= '0;
            point_ff.green_out   <= '0;
            point_ff.blue_out    <= '0;
         end else begin
            point_ff.point_x     <= x_ff;
            point_ff.point_y     <= y_ff;
            point_ff.point_z     <= depth_ff;
            point_ff.point_valid <= 1'b1;
            point_ff.red_out     <= red_ff;
            point_ff.green_out   <= green_ff;
            point_ff.blue_out    <= blue_ff;
         end
      end
   end

   assign point = point_ff;

endmodule

`default_nettype wire

### rtl/core/dbp_checker.sv
// Port-level checks of the depth back-projection unit and their binding to the top level.
`default_nettype none

module dbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] point_x,
   input logic [31:0] point_y,
   input logic [30:0] point_z,
   input logic        point_valid,
   input logic [7:0]  red_out,
   input logic [7:0]  green_out,
   input logic [7:0]  blue_out
);

   // A result beat stays offered until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // An invalid point carries zero coordinates and black colour
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !point_valid |-> (point_x == '0) && (point_y == '0) &&
         (point_z == '0) && (red_out == '0) && (green_out == '0) && (blue_out == '0))
      else $error("invalid point with nonzero fields");

   // A valid point always has a positive depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && point_valid |-> (point_z != '0))
      else $error("valid point with zero depth");

   // No result is offered in the cycle after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind depth_backprojection_point_cloud_unit dbp_checker u_dbp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .point_x     (rsp_bus.point_x),
   .point_y     (rsp_bus.point_y),
   .point_z     (rsp_bus.point_z),
   .point_valid (rsp_bus.point_valid),
   .red_out     (rsp_bus.red_out),
   .green_out   (rsp_bus.green_out),
   .blue_out    (rsp_bus.blue_out)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the depth back-projection point cloud unit.

module tb_top;
   import dbp_pkg::*;

   localparam int IMG_MAX_WIDTH  = 1024;
   localparam int IMG_MAX_HEIGHT = 1024;
   localparam int IMG_MAX_STEP   = 16;
   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_REPORTS    = 40;
   localparam longint RUN_LIMIT  = 64'd20_000_000;

   logic clock;
   logic reset;

   dbp_req_if req_bus ();
   dbp_rsp_if rsp_bus ();
   dbp_csr_if csr_bus ();

   depth_backprojection_point_cloud_unit #(
      .MAX_WIDTH  (IMG_MAX_WIDTH),
      .MAX_HEIGHT (IMG_MAX_HEIGHT),
      .MAX_STEP   (IMG_MAX_STEP)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Pixels waiting to be offered and points the block still owes us.
   pixel_type pixel_backlog[$];
   point_type expected_points[$];
   pixel_type offered_pixel;

   // Shadow copy of the camera registers and the raster counters.
   cfg_type     camera_cfg;
   int unsigned col_count, row_count, col_phase, row_phase;

   int sender_idle_pct;
   int receiver_idle_pct;
   bit long_hold;
   int mismatch_count;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT);
      $display("depth_backprojection_point_cloud_unit: mismatch");
      $finish;
   end

   // One axis of the back-projection: (|offset| * inv * depth) >> 36, saturated.
   function automatic logic [31:0] project_axis(input int offset, input logic [31:0] inv,
                                                input logic [30:0] depth);
      logic [16:0] mag;
      logic [95:0] product;
      mag = (offset < 0) ? 17'(-offset) : 17'(offset);
      product = mag * inv * depth;
      product = product >> 36;
      if (offset < 0) begin
         if (product > 96'h8000_0000) product = 96'h8000_0000;
         return 32'd0 - product[31:0];
      end
      if (product > 96'h7FFF_FFFF) product = 96'h7FFF_FFFF;
      return product[31:0];
   endfunction

   // Work out the point a pixel yields, if it is kept, and advance the raster counters.
   task automatic predict_point(input pixel_type px);
      int unsigned        eff_w, eff_s;
      logic signed [32:0] depth_sum;
      logic [63:0]        depth_val;
      point_type          pt;
      if (camera_cfg.image_width == 0) eff_w = 1;
      else if (camera_cfg.image_width > IMG_MAX_WIDTH) eff_w = IMG_MAX_WIDTH;
      else eff_w = camera_cfg.image_width;
      if (camera_cfg.sample_step == 0) eff_s = 1;
      else if (camera_cfg.sample_step > IMG_MAX_STEP) eff_s = IMG_MAX_STEP;
      else eff_s = camera_cfg.sample_step;

      if (px.frame_start) begin
         col_count = 0;
         row_count = 0;
         col_phase = 0;
         row_phase = 0;
      end

      if (col_phase == 0 && row_phase == 0) begin
         // Masked, shifted and scaled depth, clamped to the Q16.16 range.
         depth_val = '0;
         if (px.mask_level > MASK_THRESHOLD) begin
            depth_sum = $signed(px.model_depth) + $signed(camera_cfg.depth_shift);
            if (depth_sum > 0) depth_val = 64'(depth_sum);
         end
         if (camera_cfg.depth_gain != 0)
            depth_val = (depth_val * camera_cfg.depth_gain) >> 16;
         if (depth_val > 64'h7FFF_FFFF) depth_val = 64'h7FFF_FFFF;

         pt = '0;
         if (depth_val != 0) begin
            pt.point_x = project_axis(int'(col_count) * 16 - int'(camera_cfg.center_x),
                                      camera_cfg.inv_fx, depth_val[30:0]);
            pt.point_y = project_axis(int'(row_count) * 16 - int'(camera_cfg.center_y),
                                      camera_cfg.inv_fy, depth_val[30:0]);
            pt.point_z     = depth_val[30:0];
            pt.point_valid = 1'b1;
            pt.red_out     = px.red_in;
            pt.green_out   = px.green_in;
            pt.blue_out    = px.blue_in;
         end
         pt.row_last = (col_count + eff_s >= eff_w);
         expected_points = {expected_points, pt};
      end

      // Raster advance; a counter past a shrunken limit wraps on this step.
      if (col_count + 1 >= eff_w) begin
         col_count = 0;
         col_phase = 0;
         if (row_count + 1 >= IMG_MAX_HEIGHT) begin
            row_count = 0;
            row_phase = 0;
         end else begin
            row_count++;
            row_phase = (row_phase + 1 >= eff_s) ? 0 : row_phase + 1;
         end
      end else begin
         col_count++;
         col_phase = (col_phase + 1 >= eff_s) ? 0 : col_phase + 1;
      end
   endtask

   // Pixel driver: predicts on every accepted beat, then offers the next pixel or idles.
   always @(posedge clock) begin : pixel_driver
      pixel_type next_px;
      if (reset) begin
         req_bus.valid <= 1'b0;
         camera_cfg = '{image_width: 11'd1024, sample_step: 5'd1, default: '0};
         col_count = 0;
         row_count = 0;
         col_phase = 0;
         row_phase = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_point(offered_pixel);
         if (!req_bus.valid || req_bus.ready) begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_px = pixel_backlog.pop_front();
               offered_pixel         <= next_px;
               req_bus.valid         <= 1'b1;
               req_bus.model_depth   <= next_px.model_depth;
               req_bus.mask_level    <= next_px.mask_level;
               req_bus.red_in        <= next_px.red_in;
               req_bus.green_in      <= next_px.green_in;
               req_bus.blue_in       <= next_px.blue_in;
               req_bus.frame_start   <= next_px.frame_start;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
   endtask

   // Point monitor: compares each accepted beat with the oldest expected point.
   always @(posedge clock) begin : point_monitor
      point_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected point expected none actual x %h y %h z %h",
                           $time, rsp_bus.point_x, rsp_bus.point_y, rsp_bus.point_z);
            end else begin
               want = expected_points.pop_front();
               check_field("point_x", want.point_x, rsp_bus.point_x);
               check_field("point_y", want.point_y, rsp_bus.point_y);
               check_field("point_z", want.point_z, rsp_bus.point_z);
               check_field("point_valid", want.point_valid, rsp_bus.point_valid);
               check_field("red_out", want.red_out, rsp_bus.red_out);
               check_field("green_out", want.green_out, rsp_bus.green_out);
               check_field("blue_out", want.blue_out, rsp_bus.blue_out);
               check_field("row_last", want.row_last, rsp_bus.row_last);
            end
         end
         rsp_bus.ready <= !long_hold && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Register write; the shadow copy follows once the beat is taken.
   task automatic write_reg(input csr_reg_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:  camera_cfg.image_width  = value[WIDTH_REG_W-1:0];
         REG_SAMPLE_STEP:  camera_cfg.sample_step  = value[STEP_REG_W-1:0];
         REG_DEPTH_SHIFT:  camera_cfg.depth_shift  = value;
         REG_DEPTH_GAIN:   camera_cfg.depth_gain   = value[SCALE_W-1:0];
         REG_CENTER_X:     camera_cfg.center_x     = value[CENTER_W-1:0];
         REG_CENTER_Y:     camera_cfg.center_y     = value[CENTER_W-1:0];
         REG_INV_FX:       camera_cfg.inv_fx       = value;
         REG_INV_FY:       camera_cfg.inv_fy       = value;
         default: ;
      endcase
   endtask

   task automatic program_camera(input logic [31:0] width, input logic [31:0] stride,
                                 input logic [31:0] shift, input logic [31:0] scale,
                                 input logic [31:0] cx, input logic [31:0] cy,
                                 input logic [31:0] fx, input logic [31:0] fy);
      write_reg(REG_IMAGE_WIDTH, width);
      write_reg(REG_SAMPLE_STEP, stride);
      write_reg(REG_DEPTH_SHIFT, shift);
      write_reg(REG_DEPTH_GAIN, scale);
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_INV_FX, fx);
      write_reg(REG_INV_FY, fy);
   endtask

   // Mostly plausible camera setups, with corner values mixed in.
   task automatic random_camera_setup();
      int unsigned sel;
      logic [31:0] width, stride, shift, scale, cx, cy, fx, fy;
      sel = $urandom_range(99);
      if (sel < 60) width = $urandom_range(24, 1);
      else if (sel < 85) width = $urandom_range(200, 25);
      else if (sel < 95) begin
         case ($urandom_range(3))
            0: width = 0;
            1: width = 1;
            2: width = IMG_MAX_WIDTH;
            default: width = 2047;
         endcase
      end else width = $urandom_range(2047, 0);

      sel = $urandom_range(99);
      if (sel < 70) stride = $urandom_range(3, 1);
      else if (sel < 90) stride = $urandom_range(16, 4);
      else stride = $urandom_range(1) ? 0 : $urandom_range(31, 17);

      sel = $urandom_range(99);
      if (sel < 60) shift = $urandom_range(32'h2_0000) - 32'h1_0000;
      else if (sel < 80) shift = 0;
      else shift = $urandom;

      sel = $urandom_range(99);
      if (sel < 40) scale = 0;
      else if (sel < 80) scale = $urandom_range(32'h3_0000, 32'h8000);
      else scale = $urandom_range(24'hFF_FFFF);

      cx = ($urandom_range(99) < 70) ? $urandom_range(4000) : $urandom_range(16'hFFFF);
      cy = ($urandom_range(99) < 70) ? $urandom_range(4000) : $urandom_range(16'hFFFF);
      fx = ($urandom_range(99) < 70) ? $urandom_range(42949672, 2147483) : $urandom;
      fy = ($urandom_range(99) < 70) ? $urandom_range(42949672, 2147483) : $urandom;
      program_camera(width, stride, shift, scale, cx, cy, fx, fy);
   endtask

   function automatic pixel_type dir_pixel(input logic [31:0] depth, input logic [7:0] mask,
                                           input logic [23:0] rgb, input bit restart);
      pixel_type px;
      px.model_depth = depth;
      px.mask_level  = mask;
      px.red_in      = rgb[23:16];
      px.green_in    = rgb[15:8];
      px.blue_in     = rgb[7:0];
      px.frame_start = restart;
      return px;
   endfunction

   function automatic pixel_type random_pixel(input bit restart);
      pixel_type   px;
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70) px.model_depth = $urandom_range(32'h003C_0000, 32'h0000_8000);
      else if (sel < 90) px.model_depth = $urandom;
      else px.model_depth = $urandom_range(4000) - 2000;
      px.mask_level  = ($urandom_range(99) < 80) ? 8'($urandom_range(255, 129))
                                                 : 8'($urandom_range(128));
      px.red_in      = 8'($urandom);
      px.green_in    = 8'($urandom);
      px.blue_in     = 8'($urandom);
      px.frame_start = restart;
      return px;
   endfunction

   // Append one pixel to the backlog.
   task automatic enqueue_pixel(input pixel_type px);
      pixel_backlog = {pixel_backlog, px};
   endtask

   // A run of raster pixels; stray frame starts break rows when allowed.
   task automatic queue_frame(input int unsigned count, input bit first_restart,
                              input bit stray_restarts);
      for (int unsigned i = 0; i < count; i++)
         enqueue_pixel(random_pixel(i == 0 ? first_restart :
                       (stray_restarts && $urandom_range(149) == 0)));
   endtask

   // Wait until every pixel is taken and every point returned, then let the pipe settle.
   task automatic wait_until_drained();
      while (pixel_backlog.size() != 0 || req_bus.valid || expected_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      @(posedge clock);
      sender_idle_pct   <= sender_pct;
      receiver_idle_pct <= receiver_pct;
   endtask

   // Random frames, each under a fresh camera setup; optionally one long receiver stall.
   task automatic run_random_phase(input int unsigned target, input bit with_hold);
      int unsigned fed, count;
      bit          hold_pending;
      fed = 0;
      hold_pending = with_hold;
      while (fed < target) begin
         random_camera_setup();
         count = $urandom_range(60, 10);
         queue_frame(count, hold_pending || $urandom_range(3) != 0, 1'b1);
         fed += count;
         if (hold_pending) begin
            hold_pending = 1'b0;
            @(posedge clock);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold <= 1'b0;
         end
         wait_until_drained();
      end
   endtask

   initial begin : stimulus
      reset             = 1'b1;
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      long_hold         = 1'b0;
      mismatch_count    = 0;
      req_bus.valid       = 1'b0;
      req_bus.model_depth = '0;
      req_bus.mask_level  = '0;
      req_bus.red_in      = '0;
      req_bus.green_in    = '0;
      req_bus.blue_in     = '0;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = REG_IMAGE_WIDTH;
      csr_bus.data        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      set_idling(33, 70);

      // Mask threshold, depth sign and saturation, colour extremes, mid-row frame start.
      program_camera(4, 1, 0, 0, 16, 16'hFFFF, 32'hFFFF_FFFF, 32'h0100_0000);
      enqueue_pixel(dir_pixel(32'h0001_0000, 8'd129, 24'hFF00FF, 1'b1));
      enqueue_pixel(dir_pixel(32'h0001_0000, 8'd128, 24'hFFFFFF, 1'b0));
      enqueue_pixel(dir_pixel(32'h7FFF_FFFF, 8'd255, 24'h00FF00, 1'b0));
      enqueue_pixel(dir_pixel(32'h8000_0000, 8'd255, 24'hAA55AA, 1'b0));
      enqueue_pixel(dir_pixel(32'h0000_0000, 8'd255, 24'h123456, 1'b0));
      enqueue_pixel(dir_pixel(32'h0000_0001, 8'd200, 24'h55AA55, 1'b0));
      enqueue_pixel(dir_pixel(32'h0002_0000, 8'd255, 24'h010203, 1'b1));
      enqueue_pixel(dir_pixel(32'h0100_0000, 8'd255, 24'h807F80, 1'b0));
      wait_until_drained();

      // Zero width and step act as one; largest shift and scale saturate the depth.
      program_camera(0, 0, 32'h7FFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 0,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      enqueue_pixel(dir_pixel(32'h7FFF_FFFF, 8'd255, 24'hFFFFFF, 1'b1));
      enqueue_pixel(dir_pixel(32'h8000_0001, 8'd255, 24'h0F0F0F, 1'b0));
      enqueue_pixel(dir_pixel(32'h8000_0000, 8'd255, 24'hF0F0F0, 1'b0));
      enqueue_pixel(dir_pixel(32'h0000_0001, 8'd255, 24'h000000, 1'b0));
      enqueue_pixel(dir_pixel(32'h7FFF_FFFF, 8'd0, 24'hFFFFFF, 1'b0));
      wait_until_drained();

      // Most negative shift with the smallest scale; step two drops odd rows and columns.
      program_camera(2, 2, 32'h8000_0000, 1, 0, 16'hFFFF, 32'h0800_0000, 32'hFFFF_FFFF);
      enqueue_pixel(dir_pixel(32'h7FFF_FFFF, 8'd255, 24'h112233, 1'b1));
      enqueue_pixel(dir_pixel(32'h7FFF_FFFF, 8'd255, 24'h445566, 1'b0));
      enqueue_pixel(dir_pixel(32'h0001_0000, 8'd255, 24'h778899, 1'b0));
      enqueue_pixel(dir_pixel(32'h0001_0000, 8'd255, 24'hAABBCC, 1'b0));
      enqueue_pixel(dir_pixel(32'h7FFF_FFFF, 8'd255, 24'hDDEEFF, 1'b0));
      wait_until_drained();

      // Oversized width and step clamp to their maximum; large depths saturate x.
      program_camera(2047, 31, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
      queue_frame(48, 1'b1, 1'b0);
      wait_until_drained();

      run_random_phase(240, 1'b0);

      set_idling(70, 33);

      // Single-column frame under the largest step: every sixteenth row is kept.
      program_camera(1, 16, 0, 32'h1_0000, 16'h0100, 16'h0100, 32'h0020_0000, 32'h0020_0000);
      queue_frame(64, 1'b1, 1'b0);
      wait_until_drained();

      run_random_phase(240, 1'b0);

      set_idling(0, 0);
      run_random_phase(260, 1'b1);

      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("depth_backprojection_point_cloud_unit: match");
      end else begin
         $display("depth_backprojection_point_cloud_unit: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/dbp_pkg.sv
rtl/core/dbp_chan_if.sv
rtl/core/dbp_ctrl.sv
rtl/core/dbp_dp.sv
rtl/core/depth_backprojection_point_cloud_unit.sv
rtl/core/dbp_checker.sv
tb/tb_top.sv
